// File: rtl/fifo_with_indexed_access_defines.svh
// assertion macros for the queue checker
`ifndef FIFO_WITH_INDEXED_ACCESS_DEFINES_SVH
`define FIFO_WITH_INDEXED_ACCESS_DEFINES_SVH

// same-cycle implication on clk_i, off during reset
`define FWIA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("queue check failed");

// next-cycle implication on clk_i, off during reset
`define FWIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

// File: rtl/fwia_pkg.sv
package fwia_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;

  localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int DATA_W  = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_READ   = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DATA_W-1:0] data_in;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic [1:0]         status;
  } rsp_t;

  // ring slot of an offset from the head, offset never above capacity
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                               input logic [CNT_W-1:0] offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// File: rtl/fwia_ram.sv
module fwia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fifo_with_indexed_access.sv
// from accept to done_o: push passes S_EXEC, pop and read pass S_EXEC and S_RDWAIT,
// remove at position p passes S_EXEC, S_RDWAIT and S_SHIFT once per entry behind p
// one request at a time; remove moves one entry per cycle through the single ram port pair
// done_o is a one-cycle strobe and the receiver cannot stall; a new start is taken while it shows
// reset (rst_ni low, async) empties the queue; stored words stay undefined until written
module fifo_with_indexed_access (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  fwia_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output fwia_pkg::rsp_t rsp_o
);

  import fwia_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_SHIFT  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  req_t               req_q, req_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  rsp_t               rsp_q, rsp_d;
  logic               done_q, done_d;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [PTR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 fin;
  status_e              fin_st;
  logic [WORD_BITS-1:0] fin_data;
  logic                 pos_bad;

  fwia_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign pos_bad = 32'(req_q.position) >= 32'(cnt_q);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    word_d    = word_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot_of(head_q, cnt_q);
    ram_wdata = req_q.data_in[WORD_BITS-1:0];
    ram_raddr = '0;
    fin       = 1'b0;
    fin_st    = ST_OK;
    fin_data  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_q.mode)
          MODE_PUSH: begin
            fin = 1'b1;
            if (cnt_q == CNT_W'(CAPACITY)) begin
              fin_st = ST_FULL;
            end else begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
            end
          end
          MODE_POP: begin
            if (cnt_q == '0) begin
              fin    = 1'b1;
              fin_st = ST_EMPTY;
            end else begin
              ram_raddr = head_q;
              state_d   = S_RDWAIT;
            end
          end
          MODE_READ, MODE_REMOVE: begin
            if (pos_bad) begin
              fin    = 1'b1;
              fin_st = ST_RANGE;
            end else begin
              idx_d     = CNT_W'(req_q.position);
              ram_raddr = slot_of(head_q, CNT_W'(req_q.position));
              state_d   = S_RDWAIT;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_RDWAIT: begin
        fin_data = ram_rdata;
        word_d   = ram_rdata;
        unique case (req_q.mode)
          MODE_POP: begin
            head_d = slot_of(head_q, CNT_W'(1));
            cnt_d  = cnt_q - CNT_W'(1);
            fin    = 1'b1;
          end
          MODE_REMOVE: begin
            if (((CNT_W + 1)'(idx_q) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(cnt_q)) begin
              ram_raddr = slot_of(head_q, idx_q + CNT_W'(1));
              state_d   = S_SHIFT;
            end else begin
              cnt_d = cnt_q - CNT_W'(1);
              fin   = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(head_q, idx_q);
        ram_wdata = ram_rdata;
        idx_d     = idx_q + CNT_W'(1);
        fin_data  = word_q;
        if (((CNT_W + 1)'(idx_q) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(cnt_q)) begin
          ram_raddr = slot_of(head_q, idx_q + CNT_W'(2));
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
          fin   = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d           = S_IDLE;
      done_d            = 1'b1;
      rsp_d.data_out    = DATA_W'(fin_data);
      rsp_d.entry_count = COUNT_W'(cnt_d);
      rsp_d.is_empty    = (cnt_d == '0);
      rsp_d.status      = fin_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    idx_q  <= idx_d;
    word_q <= word_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: rtl/fwia_checker.sv
`include "fifo_with_indexed_access_defines.svh"

module fwia_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input fwia_pkg::req_t req_i,
  input logic           busy_o,
  input logic           done_o,
  input fwia_pkg::rsp_t rsp_o
);

  import fwia_pkg::*;

  logic take;
  assign take = start_i && !busy_o;

  `FWIA_ASSERT_NEXT(a_take_busy, take, busy_o)
  `FWIA_ASSERT_NOW(a_done_idle, done_o, !busy_o)
  `FWIA_ASSERT_NOW(a_empty_flag, done_o, rsp_o.is_empty == (rsp_o.entry_count == '0))
  `FWIA_ASSERT_NOW(a_count_max, done_o, 32'(rsp_o.entry_count) <= 32'(CAPACITY))
  `FWIA_ASSERT_NOW(a_fail_zero, done_o && (rsp_o.status != ST_OK), rsp_o.data_out == '0)

endmodule

bind fifo_with_indexed_access fwia_checker u_fwia_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .req_i  (req_i),
  .busy_o (busy_o),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// File: tb/tb_fifo_with_indexed_access.sv
module tb_fifo_with_indexed_access;
  import fwia_pkg::*;

  localparam logic [DATA_W-1:0] WORD_MASK = DATA_W'({64{1'b1}} >> (64 - WORD_BITS));
  localparam int RANDOM_WORDS = 1525;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  req_t requests_to_send[$];
  rsp_t replies_due[$];

  logic [DATA_W-1:0] shadow_words [CAPACITY];
  int unsigned shadow_head = 0;
  int unsigned shadow_fill = 0;

  int unsigned idle_left = 0;
  int unsigned words_taken = 0;
  bit quiet_run = 1'b0;
  int errors = 0;

  fifo_with_indexed_access dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic req_t make_req(mode_e m, logic [DATA_W-1:0] d, logic [POS_W-1:0] p);
    req_t r;
    r.mode = m;
    r.data_in = d;
    r.position = p;
    return r;
  endfunction

  // applies one word to the shadow queue and returns the reply it earns
  function automatic rsp_t queue_reply(req_t r);
    rsp_t rsp;
    int unsigned pos;
    int unsigned i;
    rsp = '0;
    rsp.status = ST_OK;
    pos = 32'(r.position);
    case (mode_e'(r.mode))
      MODE_PUSH: begin
        if (shadow_fill >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_words[PTR_W'((shadow_head + shadow_fill) % CAPACITY)] = r.data_in & WORD_MASK;
          shadow_fill++;
        end
      end
      MODE_POP: begin
        if (shadow_fill == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.data_out = shadow_words[PTR_W'(shadow_head)];
          shadow_head = (shadow_head + 1) % CAPACITY;
          shadow_fill--;
        end
      end
      MODE_READ: begin
        if (pos >= shadow_fill) begin
          rsp.status = ST_RANGE;
        end else begin
          rsp.data_out = shadow_words[PTR_W'((shadow_head + pos) % CAPACITY)];
        end
      end
      default: begin
        if (pos >= shadow_fill) begin
          rsp.status = ST_RANGE;
        end else begin
          rsp.data_out = shadow_words[PTR_W'((shadow_head + pos) % CAPACITY)];
          for (i = pos; i + 1 < shadow_fill; i++) begin
            shadow_words[PTR_W'((shadow_head + i) % CAPACITY)] =
              shadow_words[PTR_W'((shadow_head + i + 1) % CAPACITY)];
          end
          shadow_fill--;
        end
      end
    endcase
    rsp.data_out = rsp.data_out & WORD_MASK;
    rsp.entry_count = COUNT_W'(shadow_fill);
    rsp.is_empty = (shadow_fill == 0);
    return rsp;
  endfunction

  task automatic flag_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    logic showing;
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i <= '0;
    end else begin
      showing = start_i;
      if (start_i && !busy_o) begin
        replies_due.push_back(queue_reply(req_i));
        showing = 1'b0;
        words_taken++;
        if (words_taken % 64 == 0) begin
          quiet_run = ($urandom_range(0, 2) == 0);
        end
        idle_left = quiet_run ? 0 : $urandom_range(0, 3);
      end
      if (!showing && requests_to_send.size() > 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else begin
          req_i <= requests_to_send.pop_front();
          showing = 1'b1;
        end
      end
      start_i <= showing;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni && done_o) begin
      got = rsp_o;
      if (replies_due.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %0h", $time, got);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (got.data_out !== want.data_out) begin
          flag_field("data_out", want.data_out, got.data_out);
        end
        if (got.entry_count !== want.entry_count) begin
          flag_field("entry_count", DATA_W'(want.entry_count), DATA_W'(got.entry_count));
        end
        if (got.is_empty !== want.is_empty) begin
          flag_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
        end
        if (got.status !== want.status) begin
          flag_field("status", DATA_W'(want.status), DATA_W'(got.status));
        end
      end
    end
  end

  initial begin
    int n;
    int unsigned lean;
    int unsigned roll;
    mode_e m;
    logic [DATA_W-1:0] d;
    logic [POS_W-1:0] p;

    // empty queue corners
    requests_to_send.push_back(make_req(MODE_POP, '0, '0));
    requests_to_send.push_back(make_req(MODE_READ, '1, '0));
    requests_to_send.push_back(make_req(MODE_REMOVE, '0, '1));
    // fill to capacity, then overflow
    for (n = 0; n < CAPACITY; n++) begin
      case (n)
        0: d = '0;
        1: d = '1;
        2: d = 32'hAAAA_AAAA;
        3: d = 32'h5555_5555;
        default: d = $urandom;
      endcase
      requests_to_send.push_back(make_req(MODE_PUSH, d, POS_W'(n)));
    end
    requests_to_send.push_back(make_req(MODE_PUSH, 32'hDEAD_BEEF, '0));
    requests_to_send.push_back(make_req(MODE_READ, '0, 4'd15));
    requests_to_send.push_back(make_req(MODE_REMOVE, '0, 4'd0));
    requests_to_send.push_back(make_req(MODE_REMOVE, '0, 4'd14));
    requests_to_send.push_back(make_req(MODE_REMOVE, '0, 4'd6));
    requests_to_send.push_back(make_req(MODE_POP, '0, '0));
    requests_to_send.push_back(make_req(MODE_READ, '0, 4'd13));

    // random words, in fill, drain and mixed stretches
    lean = 0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        lean = $urandom_range(0, 2);
      end
      roll = $urandom_range(0, 99);
      case (lean)
        0: m = (roll < 65) ? MODE_PUSH : (roll < 75) ? MODE_POP :
               (roll < 90) ? MODE_READ : MODE_REMOVE;
        1: m = (roll < 20) ? MODE_PUSH : (roll < 55) ? MODE_POP :
               (roll < 75) ? MODE_READ : MODE_REMOVE;
        default: m = (roll < 35) ? MODE_PUSH : (roll < 55) ? MODE_POP :
                     (roll < 80) ? MODE_READ : MODE_REMOVE;
      endcase
      roll = $urandom_range(0, 19);
      d = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
      p = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 3)) : POS_W'($urandom_range(0, 15));
      requests_to_send.push_back(make_req(m, d, p));
    end

    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_to_send.size() > 0 || start_i || replies_due.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (24) @(posedge clk_i);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/fwia_pkg.sv
rtl/fwia_ram.sv
rtl/fifo_with_indexed_access.sv
rtl/fwia_checker.sv
tb/tb_fifo_with_indexed_access.sv
